### hdl/dtli_pkg.sv
// Shared types and constants for the descending-table linear interpolator.
// Used by every module in hdl/; depends on nothing.
package dtli_pkg;

    localparam int TABLE_POINTS = 16;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int VAL_W        = 40;
    // magnitude of a difference of two VAL_W values
    localparam int MAG_W        = VAL_W + 1;
    localparam int STEP_W       = $clog2(MAG_W);
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [CNT_W-1:0] NUM_POINTS_RST = CNT_W'(12);
    localparam logic             REG_NUM_POINTS = 1'b0;  // register index, paddr[2]

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_CLAMP  = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        point_index;
        logic signed [VAL_W-1:0] point_x;
        logic signed [VAL_W-1:0] point_y;
        logic signed [VAL_W-1:0] query_x;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
    } t_res;

    typedef enum logic [2:0] {
        SRC_FIRST,
        SRC_RD,
        SRC_PREV,
        SRC_ZERO,
        SRC_DIV
    } t_res_src;

    typedef struct packed {
        logic             wr_en;
        logic             latch_q;
        logic [IDX_W-1:0] rd_addr;
        logic             cap_first;
        logic             cap_prev;
        logic             div_start;
        logic             res_load;
        t_res_src         res_src;
        logic [1:0]       res_status;
    } t_cmd;

    typedef struct packed {
        logic q_gt_first;
        logic q_lt_rd;
        logic in_iv;
        logic ends_eq;
        logic div_done;
    } t_stat;

endpackage

### hdl/dtli_muldiv.sv
// Sequential unit for floor(a * b / d): shift-add multiply, then restoring divide.
// Depends on dtli_pkg. Expects a <= d, so the quotient fits in MAG_W bits.
module dtli_muldiv import dtli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_a,
    input  logic [MAG_W-1:0] i_b,
    input  logic [MAG_W-1:0] i_d,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quo
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } t_mstate;

    t_mstate            r_state;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_done;
    logic [MAG_W:0]     r_acc;    // high product half, later the remainder
    logic [MAG_W-1:0]   r_lo;     // multiplier bits, then low product, then quotient
    logic [MAG_W-1:0]   r_mcand;
    logic [MAG_W-1:0]   r_den;

    logic [MAG_W:0]     sum;
    logic [MAG_W+1:0]   rem2;
    logic               ge;
    logic               last_step;

    always_comb begin
        sum       = r_acc + (r_lo[0] ? {1'b0, r_mcand} : '0);
        rem2      = {r_acc, r_lo[MAG_W-1]};
        ge        = (rem2 >= {2'b00, r_den});
        last_step = (r_cnt == STEP_W'(MAG_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_lo    <= i_b;
                        r_mcand <= i_a;
                        r_den   <= i_d;
                        r_cnt   <= '0;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_acc <= {1'b0, sum[MAG_W:1]};
                    r_lo  <= {sum[0], r_lo[MAG_W-1:1]};
                    if (last_step) begin
                        r_cnt   <= '0;
                        r_state <= M_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                M_DIV: begin
                    if (ge) begin
                        r_acc <= (MAG_W+1)'(rem2 - {2'b00, r_den});
                    end else begin
                        r_acc <= rem2[MAG_W:0];
                    end
                    r_lo <= {r_lo[MAG_W-2:0], ge};
                    if (last_step) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;

endmodule

### hdl/dtli_datapath.sv
// Datapath: breakpoint memories, query and scan registers, compares, result register.
// Depends on dtli_pkg and dtli_muldiv; driven by dtli_ctrl through t_cmd / t_stat.
module dtli_datapath import dtli_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_item,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_res_valid,
    output t_res  o_result
);

    logic signed [VAL_W-1:0] mem_x [TABLE_POINTS];
    logic signed [VAL_W-1:0] mem_y [TABLE_POINTS];

    logic signed [VAL_W-1:0] r_rd_x, r_rd_y;
    logic signed [VAL_W-1:0] r_q;
    logic signed [VAL_W-1:0] r_x0, r_y0;
    logic signed [VAL_W-1:0] r_px, r_py;
    logic signed [VAL_W-1:0] r_y1;
    logic                    r_neg;
    logic                    r_res_vld;
    t_res                    r_res;

    logic signed [MAG_W-1:0] dx, dy, den;
    logic [MAG_W-1:0]        mag_dx, mag_dy, mag_den;
    logic                    div_done;
    logic [MAG_W-1:0]        quo;
    logic signed [MAG_W:0]   full;
    logic signed [VAL_W-1:0] interp;
    t_res                    n_res;

    // table write on load, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_x[i_item.point_index] <= i_item.point_x;
            mem_y[i_item.point_index] <= i_item.point_y;
        end
        r_rd_x <= mem_x[i_cmd.rd_addr];
        r_rd_y <= mem_y[i_cmd.rd_addr];
    end

    always_comb begin
        dx      = MAG_W'(r_q) - MAG_W'(r_px);
        dy      = MAG_W'(r_rd_y) - MAG_W'(r_py);
        den     = MAG_W'(r_rd_x) - MAG_W'(r_px);
        mag_dx  = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        mag_dy  = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        mag_den = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);
    end

    dtli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (mag_dx),
        .i_b     (mag_dy),
        .i_d     (mag_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // y1 +/- quotient, saturated to the value range
    always_comb begin
        if (r_neg) begin
            full = (MAG_W+1)'(r_y1) - (MAG_W+1)'({1'b0, quo});
        end else begin
            full = (MAG_W+1)'(r_y1) + (MAG_W+1)'({1'b0, quo});
        end
        if (full[MAG_W:VAL_W-1] == '0 || full[MAG_W:VAL_W-1] == '1) begin
            interp = full[VAL_W-1:0];
        end else if (full[MAG_W]) begin
            interp = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            interp = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_res.status = i_cmd.res_status;
        case (i_cmd.res_src)
            SRC_FIRST: n_res.value = r_y0;
            SRC_RD:    n_res.value = r_rd_y;
            SRC_PREV:  n_res.value = r_py;
            SRC_DIV:   n_res.value = interp;
            default:   n_res.value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_q) begin
            r_q <= i_item.query_x;
        end
        if (i_cmd.cap_first) begin
            r_x0 <= r_rd_x;
            r_y0 <= r_rd_y;
        end
        if (i_cmd.cap_first || i_cmd.cap_prev) begin
            r_px <= r_rd_x;
            r_py <= r_rd_y;
        end
        if (i_cmd.div_start) begin
            r_y1  <= r_py;
            r_neg <= dx[MAG_W-1] ^ dy[MAG_W-1] ^ den[MAG_W-1];
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.res_load;
        end
    end

    always_comb begin
        o_stat.q_gt_first = (r_q > r_x0);
        o_stat.q_lt_rd    = (r_q < r_rd_x);
        o_stat.in_iv      = (r_px >= r_q) && (r_q >= r_rd_x);
        o_stat.ends_eq    = (r_px == r_rd_x);
        o_stat.div_done   = div_done;
    end

    assign o_res_valid = r_res_vld;
    assign o_result    = r_res;

endmodule

### hdl/dtli_ctrl.sv
// Controller: issues load writes, and sequences a query through first/last reads, the interval scan and the divide.
// Depends on dtli_pkg; drives dtli_datapath through t_cmd and reads t_stat.
module dtli_ctrl import dtli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_req_type,
    input  logic [IDX_W-1:0] i_last_idx,
    input  t_stat            i_stat,
    output logic             o_busy,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_DIV
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_busy;
    logic             accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '{
            wr_en:      1'b0,
            latch_q:    1'b0,
            rd_addr:    IDX_W'(r_idx + 1'b1),
            cap_first:  1'b0,
            cap_prev:   1'b0,
            div_start:  1'b0,
            res_load:   1'b0,
            res_src:    SRC_ZERO,
            res_status: ST_NONE
        };
        case (r_state)
            S_IDLE: begin
                o_cmd.rd_addr = '0;
                if (accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.latch_q = 1'b1;
                        n_state       = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_addr   = i_last_idx;
                n_state         = S_LAST;
            end
            S_LAST: begin
                if (i_stat.q_gt_first) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_FIRST;
                    o_cmd.res_status = ST_CLAMP;
                    n_state          = S_IDLE;
                end else if (i_stat.q_lt_rd) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_RD;
                    o_cmd.res_status = ST_CLAMP;
                    n_state          = S_IDLE;
                end else if (i_last_idx == '0) begin
                    // single point, query sits exactly on it
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_FIRST;
                    o_cmd.res_status = ST_INTERP;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_addr = IDX_W'(1);
                    n_idx         = IDX_W'(1);
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                // read data is entry r_idx, prev regs hold entry r_idx-1
                if (i_stat.in_iv) begin
                    if (i_stat.ends_eq) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = SRC_PREV;
                        o_cmd.res_status = ST_INTERP;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else if (r_idx == i_last_idx) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_ZERO;
                    o_cmd.res_status = ST_NONE;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.cap_prev = 1'b1;
                    n_idx          = IDX_W'(r_idx + 1'b1);
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = SRC_DIV;
                    o_cmd.res_status = ST_INTERP;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

### hdl/descending_table_linear_interp_top.sv
// Top level of the descending-table linear interpolator: APB register, controller, datapath.
// Depends on dtli_pkg, dtli_ctrl, dtli_datapath.
//
//   channel   | handshake                          | payload
//   ----------+------------------------------------+------------------------
//   request   | start (in), busy (out)             | i_item   (t_req)
//   result    | o_res_valid strobe, one cycle      | o_result (t_res)
//   config    | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// A load word gives no result; the next word may follow at once.
// A query reads the first and last breakpoints (a clamped result ends it there), then scans
// one breakpoint per cycle over the single table read port, then, for an interval with distinct
// ends, runs the shift-add multiply and restoring divide, 41 steps each.
// busy drops as the result is registered, so a new word is taken while a result shows.
// Reset is synchronous, active low; num_points resets to 12. The receiver cannot stall.
module descending_table_linear_interp_top import dtli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_item,
    output logic               o_res_valid,
    output t_res               o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CNT_W-1:0] r_num_points;
    logic [IDX_W-1:0] last_idx;
    logic             reg_wr;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_POINTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NUM_POINTS_RST;
        end else if (reg_wr) begin
            r_num_points <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_NUM_POINTS) begin
            prdata = PDATA_W'(r_num_points);
        end else begin
            prdata = '0;
        end
    end

    // zero points counts as one, anything past the table as the full table
    always_comb begin
        if (r_num_points == '0) begin
            last_idx = '0;
        end else if (r_num_points > CNT_W'(TABLE_POINTS)) begin
            last_idx = IDX_W'(TABLE_POINTS - 1);
        end else begin
            last_idx = IDX_W'(r_num_points - 1'b1);
        end
    end

    dtli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_item.req_type),
        .i_last_idx (last_idx),
        .i_stat     (stat),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    dtli_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule

### test/tb_top.sv
// Self-checking testbench for descending_table_linear_interp_top.
// Loads breakpoint tables, fires queries and checks every result word against an
// in-bench predictor. Depends on dtli_pkg and the hdl/ sources.
`timescale 1ns / 100ps

module tb_top;
    import dtli_pkg::*;

    localparam longint VAL_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam logic [PADDR_W-1:0] ADDR_NUM_POINTS = PADDR_W'({REG_NUM_POINTS, 2'b00});
    localparam logic [PADDR_W-1:0] ADDR_SPARE      = PADDR_W'({~REG_NUM_POINTS, 2'b00});
    localparam int SETTLE_CYC = 120;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_req               req_word = '0;
    logic               res_strobe;
    t_res               res_word;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // predictor state
    logic signed [VAL_W-1:0] tab_x [TABLE_POINTS];
    logic signed [VAL_W-1:0] tab_y [TABLE_POINTS];
    logic [CNT_W-1:0]        num_pts = NUM_POINTS_RST;

    t_req   pending_words [$];
    t_res   predicted_res [$];
    longint gen_x [TABLE_POINTS];  // table as the stimulus side last wrote it
    int     idle_pct = 24;
    int     mismatches = 0;
    bit     word_taken = 1'b0;

    descending_table_linear_interp_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (req_word),
        .o_res_valid (res_strobe),
        .o_result    (res_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint fit40(longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    function automatic int eff_points(logic [CNT_W-1:0] cfg);
        if (cfg == 0) return 1;
        if (cfg > TABLE_POINTS) return TABLE_POINTS;
        return int'(cfg);
    endfunction

    function automatic t_res interp_eval(logic signed [VAL_W-1:0] qx);
        int                 n;
        bit                 hit;
        bit                 neg;
        longint             q, x1, x2, y1, y2, dx, dy, den, quo;
        logic [MAG_W-1:0]   m_dx, m_dy, m_den;
        logic [2*MAG_W-1:0] prod, ratio;
        t_res               r;
        n = eff_points(num_pts);
        q = qx;
        hit = 1'b0;
        r.value = '0;
        r.status = ST_NONE;
        if (q > tab_x[0]) begin
            r.value = tab_y[0];
            r.status = ST_CLAMP;
        end else if (q < tab_x[n-1]) begin
            r.value = tab_y[n-1];
            r.status = ST_CLAMP;
        end else if (n == 1) begin
            r.value = tab_y[0];
            r.status = ST_INTERP;
        end else begin
            for (int i = 0; i + 1 < n; i++) begin
                x1 = tab_x[i];
                x2 = tab_x[i+1];
                y1 = tab_y[i];
                y2 = tab_y[i+1];
                if (!hit && x1 >= q && q >= x2) begin
                    hit = 1'b1;
                    r.status = ST_INTERP;
                    if (x1 == x2) begin
                        r.value = tab_y[i];
                    end else begin
                        dx = q - x1;
                        dy = y2 - y1;
                        den = x2 - x1;
                        neg = ((dx < 0) != (dy < 0)) != (den < 0);
                        m_dx = MAG_W'(dx < 0 ? -dx : dx);
                        m_dy = MAG_W'(dy < 0 ? -dy : dy);
                        m_den = MAG_W'(den < 0 ? -den : den);
                        // full-width product, then truncating divide on magnitudes
                        prod = (2*MAG_W)'(m_dx) * (2*MAG_W)'(m_dy);
                        ratio = prod / (2*MAG_W)'(m_den);
                        quo = (dx == 0 || dy == 0) ? 0 : longint'(ratio[63:0]);
                        r.value = VAL_W'(fit40(neg ? y1 - quo : y1 + quo));
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic take_word(t_req w);
        if (w.req_type == REQ_LOAD) begin
            tab_x[w.point_index] = w.point_x;
            tab_y[w.point_index] = w.point_y;
        end else begin
            predicted_res = {predicted_res, interp_eval(w.query_x)};
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 200) $display("%0t mismatch: %s", $time, msg);
    endtask

    // acceptance and result checking, sampled at the rising edge
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && start && !busy) begin
            take_word(req_word);
            word_taken = 1'b1;
        end
        if (i_rst_n && res_strobe) begin
            if (predicted_res.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = predicted_res.pop_front();
                if (res_word.value !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              res_word.value, want.value));
                if (res_word.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res_word.status, want.status));
            end
        end
    end

    // request driver, changes inputs at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (word_taken || !start) begin
            word_taken = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start <= 1'b1;
                req_word <= pending_words.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic longint rand40();
        logic signed [VAL_W-1:0] b;
        b = VAL_W'({$urandom, $urandom});
        return b;
    endfunction

    function automatic longint rand_upto(longint lim);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return longint'(r % (lim + 1));
    endfunction

    task automatic push_load(int idx, longint x, longint y);
        t_req w;
        w.req_type = REQ_LOAD;
        w.point_index = IDX_W'(idx);
        w.point_x = VAL_W'(x);
        w.point_y = VAL_W'(y);
        w.query_x = VAL_W'(rand40());
        pending_words = {pending_words, w};
        gen_x[idx] = x;
    endtask

    task automatic push_query(longint q);
        t_req w;
        w.req_type = REQ_QUERY;
        w.point_index = IDX_W'($urandom);
        w.point_x = VAL_W'(rand40());
        w.point_y = VAL_W'(rand40());
        w.query_x = VAL_W'(q);
        pending_words = {pending_words, w};
    endtask

    // mostly descending tables; a few unordered or with one swapped pair
    task automatic push_table();
        int     mode, sh, k;
        longint xv [TABLE_POINTS];
        longint step, tmp;
        mode = $urandom_range(0, 19);
        sh = $urandom_range(0, 34);
        xv[0] = rand_upto(longint'(1) << 39) - (longint'(1) << 38);
        for (int i = 1; i < TABLE_POINTS; i++) begin
            step = ($urandom_range(0, 7) == 0) ? 0 : rand_upto(longint'(1) << sh);
            xv[i] = xv[i-1] - step;
        end
        if (mode == 0) begin
            for (int i = 0; i < TABLE_POINTS; i++) xv[i] = rand40();
        end else if (mode == 1) begin
            k = $urandom_range(0, TABLE_POINTS - 2);
            tmp = xv[k];
            xv[k] = xv[k+1];
            xv[k+1] = tmp;
        end
        if ($urandom_range(0, 1)) begin
            for (int i = 0; i < TABLE_POINTS; i++) push_load(i, xv[i], rand40());
        end else begin
            for (int i = TABLE_POINTS - 1; i >= 0; i--) push_load(i, xv[i], rand40());
        end
    endtask

    task automatic push_query_mix(int n);
        int     j;
        longint q, lo, hi;
        case ($urandom_range(0, 11))
            0: q = rand40();
            1: q = fit40(gen_x[0] + 1 + rand_upto(longint'(1) << $urandom_range(0, 36)));
            2: q = fit40(gen_x[n-1] - 1 - rand_upto(longint'(1) << $urandom_range(0, 36)));
            3: q = gen_x[$urandom_range(0, n - 1)];
            4: q = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            default: begin
                if (n < 2) begin
                    q = gen_x[0];
                end else begin
                    j = $urandom_range(0, n - 2);
                    hi = gen_x[j];
                    lo = gen_x[j+1];
                    q = (hi >= lo) ? lo + rand_upto(hi - lo) : hi + rand_upto(lo - hi);
                end
            end
        endcase
        push_query(q);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_NUM_POINTS) num_pts = data[CNT_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // sender holds until every word is taken and every result is back
    task automatic wait_idle();
        while (pending_words.size() != 0 || start || predicted_res.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    initial begin
        int                 n;
        logic [CNT_W-1:0]   cfg;
        logic [PDATA_W-1:0] wd;
        longint             stp, xk;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            tab_x[i] = '0;
            tab_y[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale table, first interval flat, widest swing next
        stp = longint'(1) << 35;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            xk = (i == 0) ? VAL_MAX : VAL_MAX - (i - 1) * stp;
            if (i == TABLE_POINTS - 1) xk = VAL_MIN;
            push_load(i, xk, (i == 1) ? VAL_MIN : (i == 2) ? VAL_MAX : rand40());
        end
        push_query(VAL_MAX);              // flat first interval
        push_query(VAL_MIN);              // below the last point in use
        push_query(gen_x[1] - stp / 3);   // full-range ordinate swing
        push_query(gen_x[2] - 1);
        push_query(0);
        push_query(-1);
        push_query(gen_x[7]);             // exact breakpoint hit
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: cfg = CNT_W'(16);
                1: cfg = CNT_W'(1);
                2: cfg = CNT_W'(2);
                3: cfg = CNT_W'(31);
                4: cfg = CNT_W'(0);
                default: cfg = CNT_W'($urandom_range(3, 15));
            endcase
            if ($urandom_range(0, 1)) apb_write(ADDR_SPARE, $urandom);
            wd = $urandom;
            wd[CNT_W-1:0] = cfg;
            apb_write(ADDR_NUM_POINTS, wd);
            idle_pct = (p == 3) ? 0 : 24;
            n = eff_points(cfg);
            repeat (2) begin
                push_table();
                repeat (70) begin
                    if ($urandom_range(0, 19) == 0)
                        push_load($urandom_range(0, TABLE_POINTS - 1), rand40(), rand40());
                    else
                        push_query_mix(n);
                end
                wait_idle();
            end
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
